[rtl/core/cscmd_pkg.sv]
// shared types, codes and command derivation for the cover switch command translator
package cscmd_pkg;

    // widths of the configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SW_KIND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LCL_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COVER_NUMBER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COVER_COUNT  = 3'd5;

    // button event codes
    localparam logic [1:0] EVT_PRESS   = 2'd0;
    localparam logic [1:0] EVT_LONG    = 2'd1;
    localparam logic [1:0] EVT_RELEASE = 2'd2;

    // switch action codes
    localparam logic [2:0] ACT_RELEASED   = 3'd0;
    localparam logic [2:0] ACT_OPEN       = 3'd1;
    localparam logic [2:0] ACT_CLOSE      = 3'd2;
    localparam logic [2:0] ACT_STOP       = 3'd3;
    localparam logic [2:0] ACT_LONG_OPEN  = 3'd4;
    localparam logic [2:0] ACT_LONG_CLOSE = 3'd5;

    // cover command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // motion codes
    localparam logic [1:0] MOV_STOPPED = 2'd0;
    localparam logic [1:0] MOV_OPENING = 2'd1;
    localparam logic [1:0] MOV_CLOSING = 2'd2;

    // cover modes
    localparam logic [1:0] MODE_IMMEDIATE = 2'd0;
    localparam logic [1:0] MODE_SHORT     = 2'd1;
    localparam logic [1:0] MODE_LONG      = 2'd2;
    localparam logic [1:0] MODE_HYBRID    = 2'd3;

    // reset values of the configuration registers
    localparam logic       RST_SW_KIND      = 1'b0;
    localparam logic       RST_REVERSAL     = 1'b0;
    localparam logic [1:0] RST_LCL_MODE     = MODE_HYBRID;
    localparam logic [1:0] RST_BOUND_MODE   = MODE_HYBRID;
    localparam logic [3:0] RST_COVER_NUMBER = 4'd1;
    localparam logic [3:0] RST_COVER_COUNT  = 4'd1;

    typedef struct packed {
        logic       sw_kind;
        logic       reversal;
        logic [1:0] lcl_mode;
        logic [1:0] bound_mode;
        logic [3:0] cover_number;
        logic [3:0] cover_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0] command;
        logic       open_pressed;
        logic       close_pressed;
        logic       open_long;
        logic       close_long;
        logic [1:0] local_moving;
        logic       network_joined;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic       action_changed;
        logic [1:0] lcl_cmd;
        logic [1:0] bound_cmd;
    } t_out_item;

    // cover command for a new action, given mode and current motion of that cover
    function automatic logic [1:0] derive_cmd(
        input logic [2:0] nxt,
        input logic [2:0] cur,
        input logic [1:0] mode,
        input logic [1:0] moving,
        input logic       toggle
    );
        logic [1:0] c;
        logic       fixed;
        c     = CMD_NONE;
        fixed = 1'b0;
        if (nxt == ACT_STOP) begin
            c     = CMD_STOP;
            fixed = 1'b1;
        end else if (toggle) begin
            fixed = 1'b1;
            if (nxt == ACT_OPEN) begin
                c = CMD_OPEN;
            end else if (nxt == ACT_CLOSE) begin
                c = CMD_CLOSE;
            end
        end else begin
            case (mode)
                MODE_IMMEDIATE: begin
                    if (nxt == ACT_OPEN) begin
                        c = CMD_OPEN;
                    end else if (nxt == ACT_CLOSE) begin
                        c = CMD_CLOSE;
                    end
                end
                MODE_SHORT: begin
                    if (nxt == ACT_RELEASED) begin
                        if (cur == ACT_OPEN) begin
                            c = CMD_OPEN;
                        end else if (cur == ACT_CLOSE) begin
                            c = CMD_CLOSE;
                        end
                    end
                end
                MODE_LONG: begin
                    if (nxt == ACT_LONG_OPEN) begin
                        c = CMD_OPEN;
                    end else if (nxt == ACT_LONG_CLOSE) begin
                        c = CMD_CLOSE;
                    end
                end
                default: begin
                    // hybrid: long press starts motion, its release stops it; a short press acts on its release
                    if (nxt == ACT_LONG_OPEN) begin
                        c     = CMD_OPEN;
                        fixed = 1'b1;
                    end else if (nxt == ACT_LONG_CLOSE) begin
                        c     = CMD_CLOSE;
                        fixed = 1'b1;
                    end else if (nxt == ACT_RELEASED) begin
                        if (cur == ACT_LONG_OPEN || cur == ACT_LONG_CLOSE) begin
                            c     = CMD_STOP;
                            fixed = 1'b1;
                        end else if (cur == ACT_OPEN) begin
                            c = CMD_OPEN;
                        end else if (cur == ACT_CLOSE) begin
                            c = CMD_CLOSE;
                        end
                    end
                end
            endcase
        end
        // unless the command is fixed, pressing again the way the cover already moves stops it
        if (!fixed) begin
            if (c == CMD_OPEN && moving == MOV_OPENING) begin
                c = CMD_STOP;
            end else if (c == CMD_CLOSE && moving == MOV_CLOSING) begin
                c = CMD_STOP;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/cscmd_in_if.sv]
// input channel carrying one button event item
interface cscmd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic       open_pressed;
    logic       close_pressed;
    logic       open_long;
    logic       close_long;
    logic [1:0] local_moving;
    logic       network_joined;

    modport source (
        output valid, command, open_pressed, close_pressed, open_long, close_long,
               local_moving, network_joined,
        input  ready
    );

    modport sink (
        input  valid, command, open_pressed, close_pressed, open_long, close_long,
               local_moving, network_joined,
        output ready
    );
endinterface

[rtl/core/cscmd_out_if.sv]
// output channel carrying one translated command item
interface cscmd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       action_changed;
    logic [1:0] lcl_cmd;
    logic [1:0] bound_cmd;

    modport source (
        output valid, action, action_changed, lcl_cmd, bound_cmd,
        input  ready
    );

    modport sink (
        input  valid, action, action_changed, lcl_cmd, bound_cmd,
        output ready
    );
endinterface

[rtl/core/cscmd_cfg_regs.sv]
// configuration registers of the cover switch command translator
module cscmd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cscmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cscmd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output cscmd_pkg::t_cfg                  o_cfg,
    output logic                             o_type_wr,
    output logic                             o_type_new
);

    cscmd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sw_kind      <= cscmd_pkg::RST_SW_KIND;
            r_cfg.reversal     <= cscmd_pkg::RST_REVERSAL;
            r_cfg.lcl_mode     <= cscmd_pkg::RST_LCL_MODE;
            r_cfg.bound_mode   <= cscmd_pkg::RST_BOUND_MODE;
            r_cfg.cover_number <= cscmd_pkg::RST_COVER_NUMBER;
            r_cfg.cover_count  <= cscmd_pkg::RST_COVER_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cscmd_pkg::REG_SW_KIND:      r_cfg.sw_kind      <= i_cfg_wdata[0];
                cscmd_pkg::REG_REVERSAL:     r_cfg.reversal     <= i_cfg_wdata[0];
                cscmd_pkg::REG_LCL_MODE:     r_cfg.lcl_mode     <= i_cfg_wdata[1:0];
                cscmd_pkg::REG_BOUND_MODE:   r_cfg.bound_mode   <= i_cfg_wdata[1:0];
                cscmd_pkg::REG_COVER_NUMBER: r_cfg.cover_number <= i_cfg_wdata[3:0];
                cscmd_pkg::REG_COVER_COUNT:  r_cfg.cover_count  <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg      = r_cfg;
    // switch type write also restarts the action tracking in the core
    assign o_type_wr  = i_cfg_we && (i_cfg_idx == cscmd_pkg::REG_SW_KIND);
    // switch type being written, the register only shows it after the edge
    assign o_type_new = i_cfg_wdata[0];

endmodule

[rtl/core/cscmd_core.sv]
// action tracking and cover command derivation for one event item
module cscmd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cscmd_pkg::t_in_item  i_item,
    input  logic                 i_advance,
    input  cscmd_pkg::t_cfg      i_cfg,
    input  logic                 i_type_wr,
    input  logic                 i_type_new,
    output cscmd_pkg::t_out_item o_result
);

    logic [2:0] r_action;
    logic [2:0] n_action;
    logic [1:0] r_bound_motion;
    logic [1:0] n_bound_motion;

    logic       have;
    logic [2:0] nxt;
    logic       changed;
    logic       local_ok;
    logic [1:0] lcmd;
    logic [1:0] bcmd;
    logic       op;
    logic       cp;
    logic       rev;
    logic       toggle;

    assign op     = i_item.open_pressed;
    assign cp     = i_item.close_pressed;
    assign rev    = i_cfg.reversal;
    assign toggle = i_cfg.sw_kind;

    // new action from the event and the button levels
    always_comb begin
        have = 1'b0;
        nxt  = r_action;
        case (i_item.command)
            cscmd_pkg::EVT_PRESS: begin
                if (op && cp) begin
                    nxt  = cscmd_pkg::ACT_STOP;
                    have = 1'b1;
                end else if (op) begin
                    nxt  = rev ? cscmd_pkg::ACT_CLOSE : cscmd_pkg::ACT_OPEN;
                    have = 1'b1;
                end else if (cp) begin
                    nxt  = rev ? cscmd_pkg::ACT_OPEN : cscmd_pkg::ACT_CLOSE;
                    have = 1'b1;
                end
            end
            cscmd_pkg::EVT_LONG: begin
                if (!toggle && !(op && cp)) begin
                    if (i_item.open_long) begin
                        nxt  = rev ? cscmd_pkg::ACT_LONG_CLOSE : cscmd_pkg::ACT_LONG_OPEN;
                        have = 1'b1;
                    end else if (i_item.close_long) begin
                        nxt  = rev ? cscmd_pkg::ACT_LONG_OPEN : cscmd_pkg::ACT_LONG_CLOSE;
                        have = 1'b1;
                    end
                end
            end
            cscmd_pkg::EVT_RELEASE: begin
                if (!op && !cp) begin
                    nxt  = toggle ? cscmd_pkg::ACT_STOP : cscmd_pkg::ACT_RELEASED;
                    have = 1'b1;
                end else if (toggle) begin
                    if (op) begin
                        nxt = rev ? cscmd_pkg::ACT_CLOSE : cscmd_pkg::ACT_OPEN;
                    end else begin
                        nxt = rev ? cscmd_pkg::ACT_OPEN : cscmd_pkg::ACT_CLOSE;
                    end
                    have = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign changed  = have && (nxt != r_action);
    assign local_ok = (i_cfg.cover_number != 4'd0) &&
                      (i_cfg.cover_number <= i_cfg.cover_count);

    // local and bound commands, bound motion tracking
    always_comb begin
        lcmd           = cscmd_pkg::CMD_NONE;
        bcmd           = cscmd_pkg::CMD_NONE;
        n_action       = r_action;
        n_bound_motion = r_bound_motion;
        if (changed) begin
            n_action = nxt;
            if (local_ok) begin
                lcmd = cscmd_pkg::derive_cmd(nxt, r_action, i_cfg.lcl_mode,
                                             i_item.local_moving, toggle);
                if (i_cfg.lcl_mode == i_cfg.bound_mode) begin
                    bcmd = lcmd;
                end
            end
            if (bcmd == cscmd_pkg::CMD_NONE) begin
                bcmd = cscmd_pkg::derive_cmd(nxt, r_action, i_cfg.bound_mode,
                                             r_bound_motion, toggle);
            end
            if (i_item.network_joined && bcmd != cscmd_pkg::CMD_NONE) begin
                case (bcmd)
                    cscmd_pkg::CMD_OPEN:  n_bound_motion = cscmd_pkg::MOV_OPENING;
                    cscmd_pkg::CMD_CLOSE: n_bound_motion = cscmd_pkg::MOV_CLOSING;
                    default:              n_bound_motion = cscmd_pkg::MOV_STOPPED;
                endcase
            end else begin
                bcmd = cscmd_pkg::CMD_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action       <= cscmd_pkg::ACT_RELEASED;
            r_bound_motion <= cscmd_pkg::MOV_STOPPED;
        end else if (i_type_wr) begin
            r_action <= i_type_new ? cscmd_pkg::ACT_STOP : cscmd_pkg::ACT_RELEASED;
        end else if (i_advance) begin
            r_action       <= n_action;
            r_bound_motion <= n_bound_motion;
        end
    end

    assign o_result.action         = n_action;
    assign o_result.action_changed = changed;
    assign o_result.lcl_cmd        = lcmd;
    assign o_result.bound_cmd      = bcmd;

endmodule

[rtl/core/cover_switch_command_translator.sv]
// top level of the cover switch command translator
// The block turns open/close button events into a six-valued switch action and, when the
// action changes, into a command for the local cover and one for the bound remote covers.
// One event item is accepted every clock cycle: an input register takes the item, the
// action decode and command derivation sit in one short combinational step behind it, and
// a result register holds the finished item, so every item gives exactly one result, held
// on the output until it is taken. The result register parts the two sides: a new item is
// accepted while a result waits, and only when both the input register and the result
// register are full and the result is not taken does the input side stall. The action and
// the tracked bound cover motion are updated as an item moves from the input register into
// the result register, so the next item already sees them. Configuration is written through
// a plain write port (index, data); the user is to write it only while no item is in
// flight, which the block itself does not enforce. A write of the switch type also sets
// the action to stop for a toggle switch or released for momentary buttons, and issues no
// command. Indexes beyond the register list are ignored.
module cover_switch_command_translator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cscmd_in_if.sink                         i_in,
    cscmd_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [cscmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cscmd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    cscmd_pkg::t_cfg      cfg;
    logic                 type_wr;
    logic                 type_new;
    cscmd_pkg::t_out_item result;

    // input register
    logic                 r_in_valid;
    cscmd_pkg::t_in_item  r_in;
    // result register
    logic                 r_out_valid;
    cscmd_pkg::t_out_item r_out;

    logic                 advance;

    // item moves into the result register when that one is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.command        <= i_in.command;
            r_in.open_pressed   <= i_in.open_pressed;
            r_in.close_pressed  <= i_in.close_pressed;
            r_in.open_long      <= i_in.open_long;
            r_in.close_long     <= i_in.close_long;
            r_in.local_moving   <= i_in.local_moving;
            r_in.network_joined <= i_in.network_joined;
        end
    end

    cscmd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_type_wr   (type_wr),
        .o_type_new  (type_new)
    );

    cscmd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (r_in),
        .i_advance  (advance),
        .i_cfg      (cfg),
        .i_type_wr  (type_wr),
        .i_type_new (type_new),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_out.action;
    assign o_out.action_changed = r_out.action_changed;
    assign o_out.lcl_cmd        = r_out.lcl_cmd;
    assign o_out.bound_cmd      = r_out.bound_cmd;

    // no command goes out for an event that left the action as it was
    a_cmd_needs_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.action_changed) |->
            (r_out.lcl_cmd == cscmd_pkg::CMD_NONE && r_out.bound_cmd == cscmd_pkg::CMD_NONE))
        else $error("command issued without action change");

    // local cover is commanded only when the configured cover exists
    a_local_cover_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (result.lcl_cmd != cscmd_pkg::CMD_NONE) |->
            (cfg.cover_number != 4'd0 && cfg.cover_number <= cfg.cover_count))
        else $error("local command without a valid local cover");

    // bound covers are commanded only while joined
    a_bound_needs_join: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.network_joined |=> (r_out.bound_cmd == cscmd_pkg::CMD_NONE))
        else $error("bound command while not joined");

    // a waiting item in the input register is not lost while the result is stalled
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled input item changed");

endmodule

[dv/cover_switch_command_translator_test.sv]
// self-checking testbench for the cover switch command translator
`timescale 1ns / 1ps

module cover_switch_command_translator_test;

    // codes the package leaves out: spare event, spare motion, spare register index
    localparam logic [1:0]                     EVT_UNUSED  = 2'd3;
    localparam logic [1:0]                     MOV_UNKNOWN = 2'd3;
    localparam logic [cscmd_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 3'd6;

    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 130;
    localparam int MAX_WAIT      = 14;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                             cfg_we;
    logic [cscmd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [cscmd_pkg::CFG_DATA_W-1:0] cfg_wdata;

    cscmd_in_if  ev_ch ();
    cscmd_out_if cmd_ch ();

    cover_switch_command_translator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (ev_ch),
        .o_out       (cmd_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // mirror of the registers and the translator state
    cscmd_pkg::t_cfg cfg_mirror;
    logic [2:0]      action_now;
    logic [1:0]      remote_motion;

    // translated commands still owed by the block, oldest first
    cscmd_pkg::t_out_item expected_cmds[$];

    int  error_cnt   = 0;
    int  items_sent  = 0;
    int  results_ok  = 0;
    int  cfg_writes  = 0;
    int  settings    = 0;
    // per-side idling switches, cleared for stretches of back-to-back traffic
    bit  send_idle   = 1'b1;
    bit  take_idle   = 1'b1;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // command for one cover side when the action moves to nxt
    function automatic logic [1:0] cover_cmd(logic [2:0] nxt, logic [1:0] mode,
                                             logic [1:0] moving);
        logic [1:0] c;
        c = cscmd_pkg::CMD_NONE;
        // stop always goes straight out
        if (nxt == cscmd_pkg::ACT_STOP) return cscmd_pkg::CMD_STOP;
        // toggle switch follows its level, modes do not apply
        if (cfg_mirror.sw_kind) begin
            if (nxt == cscmd_pkg::ACT_OPEN) return cscmd_pkg::CMD_OPEN;
            if (nxt == cscmd_pkg::ACT_CLOSE) return cscmd_pkg::CMD_CLOSE;
            return cscmd_pkg::CMD_NONE;
        end
        case (mode)
            cscmd_pkg::MODE_IMMEDIATE: begin
                if (nxt == cscmd_pkg::ACT_OPEN) c = cscmd_pkg::CMD_OPEN;
                else if (nxt == cscmd_pkg::ACT_CLOSE) c = cscmd_pkg::CMD_CLOSE;
            end
            cscmd_pkg::MODE_SHORT: begin
                // act on the release of a short press
                if (nxt == cscmd_pkg::ACT_RELEASED) begin
                    if (action_now == cscmd_pkg::ACT_OPEN) c = cscmd_pkg::CMD_OPEN;
                    else if (action_now == cscmd_pkg::ACT_CLOSE) c = cscmd_pkg::CMD_CLOSE;
                end
            end
            cscmd_pkg::MODE_LONG: begin
                if (nxt == cscmd_pkg::ACT_LONG_OPEN) c = cscmd_pkg::CMD_OPEN;
                else if (nxt == cscmd_pkg::ACT_LONG_CLOSE) c = cscmd_pkg::CMD_CLOSE;
            end
            default: begin
                // hybrid: long press moves until release, short press acts on release
                if (nxt == cscmd_pkg::ACT_LONG_OPEN) return cscmd_pkg::CMD_OPEN;
                if (nxt == cscmd_pkg::ACT_LONG_CLOSE) return cscmd_pkg::CMD_CLOSE;
                if (nxt == cscmd_pkg::ACT_RELEASED) begin
                    if (action_now == cscmd_pkg::ACT_LONG_OPEN ||
                        action_now == cscmd_pkg::ACT_LONG_CLOSE)
                        return cscmd_pkg::CMD_STOP;
                    if (action_now == cscmd_pkg::ACT_OPEN) c = cscmd_pkg::CMD_OPEN;
                    else if (action_now == cscmd_pkg::ACT_CLOSE) c = cscmd_pkg::CMD_CLOSE;
                end
            end
        endcase
        // asking again for the way the cover already moves means stop
        if (c == cscmd_pkg::CMD_OPEN && moving == cscmd_pkg::MOV_OPENING)
            return cscmd_pkg::CMD_STOP;
        if (c == cscmd_pkg::CMD_CLOSE && moving == cscmd_pkg::MOV_CLOSING)
            return cscmd_pkg::CMD_STOP;
        return c;
    endfunction

    // next action and cover commands for one button event; updates the mirror state
    function automatic cscmd_pkg::t_out_item translate_event(cscmd_pkg::t_in_item ev);
        logic [2:0]           nxt;
        logic                 hit;
        logic                 cover_ok;
        logic                 rev;
        cscmd_pkg::t_out_item r;
        nxt = action_now;
        hit = 1'b0;
        rev = cfg_mirror.reversal;
        r   = '0;
        case (ev.command)
            cscmd_pkg::EVT_PRESS: begin
                hit = ev.open_pressed | ev.close_pressed;
                if (ev.open_pressed && ev.close_pressed)
                    nxt = cscmd_pkg::ACT_STOP;
                else if (ev.open_pressed)
                    nxt = rev ? cscmd_pkg::ACT_CLOSE : cscmd_pkg::ACT_OPEN;
                else if (ev.close_pressed)
                    nxt = rev ? cscmd_pkg::ACT_OPEN : cscmd_pkg::ACT_CLOSE;
            end
            cscmd_pkg::EVT_LONG: begin
                // long press only counts for momentary buttons with one button held
                if (!cfg_mirror.sw_kind && !(ev.open_pressed && ev.close_pressed)) begin
                    hit = ev.open_long | ev.close_long;
                    if (ev.open_long)
                        nxt = rev ? cscmd_pkg::ACT_LONG_CLOSE : cscmd_pkg::ACT_LONG_OPEN;
                    else if (ev.close_long)
                        nxt = rev ? cscmd_pkg::ACT_LONG_OPEN : cscmd_pkg::ACT_LONG_CLOSE;
                end
            end
            cscmd_pkg::EVT_RELEASE: begin
                if (!ev.open_pressed && !ev.close_pressed) begin
                    hit = 1'b1;
                    nxt = cfg_mirror.sw_kind ? cscmd_pkg::ACT_STOP : cscmd_pkg::ACT_RELEASED;
                end else if (cfg_mirror.sw_kind) begin
                    // toggle switch: the level left standing gives the direction
                    hit = 1'b1;
                    if (ev.open_pressed) nxt = rev ? cscmd_pkg::ACT_CLOSE : cscmd_pkg::ACT_OPEN;
                    else nxt = rev ? cscmd_pkg::ACT_OPEN : cscmd_pkg::ACT_CLOSE;
                end
            end
            default: ;
        endcase

        if (hit && nxt != action_now) begin
            cover_ok = cfg_mirror.cover_number != 4'd0 &&
                       cfg_mirror.cover_number <= cfg_mirror.cover_count;
            r.action_changed = 1'b1;
            if (cover_ok) begin
                r.lcl_cmd = cover_cmd(nxt, cfg_mirror.lcl_mode, ev.local_moving);
                if (cfg_mirror.lcl_mode == cfg_mirror.bound_mode) r.bound_cmd = r.lcl_cmd;
            end
            // bound side falls back to its own mode and tracked motion
            if (r.bound_cmd == cscmd_pkg::CMD_NONE)
                r.bound_cmd = cover_cmd(nxt, cfg_mirror.bound_mode, remote_motion);
            action_now = nxt;
            if (ev.network_joined && r.bound_cmd != cscmd_pkg::CMD_NONE) begin
                case (r.bound_cmd)
                    cscmd_pkg::CMD_OPEN:  remote_motion = cscmd_pkg::MOV_OPENING;
                    cscmd_pkg::CMD_CLOSE: remote_motion = cscmd_pkg::MOV_CLOSING;
                    default:              remote_motion = cscmd_pkg::MOV_STOPPED;
                endcase
            end else begin
                r.bound_cmd = cscmd_pkg::CMD_NONE;
            end
        end
        r.action = action_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic cscmd_pkg::t_in_item make_ev(logic [1:0] cmd, logic op, logic cp,
                                                    logic ol, logic cl, logic [1:0] mov,
                                                    logic joined);
        cscmd_pkg::t_in_item ev;
        ev.command        = cmd;
        ev.open_pressed   = op;
        ev.close_pressed  = cp;
        ev.open_long      = ol;
        ev.close_long     = cl;
        ev.local_moving   = mov;
        ev.network_joined = joined;
        return ev;
    endfunction

    // offer one event item, after a random gap while send_idle is set; returns at the accepting
    // edge with valid still high so a following item can go out back to back
    task automatic send_event(cscmd_pkg::t_in_item ev);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev_ch.valid          <= 1'b1;
        ev_ch.command        <= ev.command;
        ev_ch.open_pressed   <= ev.open_pressed;
        ev_ch.close_pressed  <= ev.close_pressed;
        ev_ch.open_long      <= ev.open_long;
        ev_ch.close_long     <= ev.close_long;
        ev_ch.local_moving   <= ev.local_moving;
        ev_ch.network_joined <= ev.network_joined;
        do @(posedge i_clk); while (!ev_ch.ready);
        expected_cmds.push_back(translate_event(ev));
        items_sent++;
    endtask

    // stop offering items and let every owed result drain out
    task automatic wait_idle();
        ev_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        // two-stage pipe, let it settle before returning
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [cscmd_pkg::CFG_IDX_W-1:0] idx,
                             logic [cscmd_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            cscmd_pkg::REG_SW_KIND: begin
                cfg_mirror.sw_kind = val[0];
                // switch type write re-arms the action
                action_now = val[0] ? cscmd_pkg::ACT_STOP : cscmd_pkg::ACT_RELEASED;
            end
            cscmd_pkg::REG_REVERSAL:     cfg_mirror.reversal     = val[0];
            cscmd_pkg::REG_LCL_MODE:     cfg_mirror.lcl_mode     = val[1:0];
            cscmd_pkg::REG_BOUND_MODE:   cfg_mirror.bound_mode   = val[1:0];
            cscmd_pkg::REG_COVER_NUMBER: cfg_mirror.cover_number = val;
            cscmd_pkg::REG_COVER_COUNT:  cfg_mirror.cover_count  = val;
            default: ;
        endcase
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(logic st, logic rv, logic [1:0] lm, logic [1:0] bm,
                               logic [3:0] cn, logic [3:0] cc);
        write_cfg(cscmd_pkg::REG_SW_KIND, {3'd0, st});
        write_cfg(cscmd_pkg::REG_REVERSAL, {3'd0, rv});
        write_cfg(cscmd_pkg::REG_LCL_MODE, {2'd0, lm});
        write_cfg(cscmd_pkg::REG_BOUND_MODE, {2'd0, bm});
        write_cfg(cscmd_pkg::REG_COVER_NUMBER, cn);
        write_cfg(cscmd_pkg::REG_COVER_COUNT, cc);
        settings++;
    endtask

    // one realistic button gesture with random levels, motion and join state
    task automatic send_gesture();
        int   pick;
        logic op;
        logic cp;
        pick = $urandom_range(0, 4);
        op   = (pick < 2) || (pick == 4);
        cp   = (pick >= 2);
        if (cfg_mirror.sw_kind) begin
            // toggle: flip to a level, sometimes back to neutral
            send_event(make_ev(cscmd_pkg::EVT_RELEASE, op, cp, 1'b0, 1'b0,
                               2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0));
            if ($urandom_range(0, 1))
                send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                                   2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0));
        end else begin
            send_event(make_ev(cscmd_pkg::EVT_PRESS, op, cp, 1'b0, 1'b0,
                               2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0));
            if ($urandom_range(0, 1))
                send_event(make_ev(cscmd_pkg::EVT_LONG, op, cp, op, cp,
                                   2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0));
            // now and then a release while a button is still down
            if ($urandom_range(0, 5) == 0)
                send_event(make_ev(cscmd_pkg::EVT_RELEASE, op, cp, 1'b0, 1'b0,
                                   2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0));
            send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                               2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: momentary buttons, hybrid on both sides, cover 1 of 1
    task automatic test_default_buttons();
        // short press open acts on release, then again with the cover already opening
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b1, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b1, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_OPENING, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_OPENING, 1'b1));
        // long close moves, its release stops
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b0, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_LONG, 1'b0, 1'b1, 1'b0, 1'b1,
                           cscmd_pkg::MOV_CLOSING, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_CLOSING, 1'b1));
        // both buttons give stop; long press with both held is ignored
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b1, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_LONG, 1'b1, 1'b1, 1'b1, 1'b1,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        // spare event code, empty press, release with a button still down
        send_event(make_ev(EVT_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, MOV_UNKNOWN, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b0, 1'b0, 1'b1, 1'b1,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        // not joined, unknown motion code
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b0));
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b1, 1'b0, 1'b0, 1'b0, MOV_UNKNOWN, 1'b0));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0, MOV_UNKNOWN, 1'b0));
        wait_idle();
    endtask

    // toggle switch with swapped buttons
    task automatic test_toggle_reversal();
        write_cfg(cscmd_pkg::REG_SW_KIND, 4'd1);
        write_cfg(cscmd_pkg::REG_REVERSAL, 4'd1);
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b1, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_LONG, 1'b1, 1'b0, 1'b1, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_OPENING, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b0, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b0, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        wait_idle();
    endtask

    // local cover missing or out of range, sides in different modes
    task automatic test_cover_selection();
        write_cfg(cscmd_pkg::REG_SW_KIND, 4'd0);
        write_cfg(cscmd_pkg::REG_REVERSAL, 4'd0);
        write_cfg(cscmd_pkg::REG_COVER_NUMBER, 4'd0);
        write_cfg(cscmd_pkg::REG_LCL_MODE, {2'd0, cscmd_pkg::MODE_IMMEDIATE});
        write_cfg(cscmd_pkg::REG_BOUND_MODE, {2'd0, cscmd_pkg::MODE_SHORT});
        // a write to a spare index must change nothing
        write_cfg(REG_UNUSED, 4'hf);
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b1, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        wait_idle();
        write_cfg(cscmd_pkg::REG_COVER_NUMBER, 4'd3);
        write_cfg(cscmd_pkg::REG_COVER_COUNT, 4'd2);
        write_cfg(cscmd_pkg::REG_BOUND_MODE, {2'd0, cscmd_pkg::MODE_LONG});
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b0, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_CLOSING, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_LONG, 1'b0, 1'b1, 1'b0, 1'b1,
                           cscmd_pkg::MOV_CLOSING, 1'b1));
        wait_idle();
        // cover number back in range: local immediate, bound long
        write_cfg(cscmd_pkg::REG_COVER_NUMBER, 4'd2);
        send_event(make_ev(cscmd_pkg::EVT_RELEASE, 1'b0, 1'b0, 1'b0, 1'b0,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_PRESS, 1'b0, 1'b1, 1'b0, 1'b0,
                           cscmd_pkg::MOV_CLOSING, 1'b1));
        send_event(make_ev(cscmd_pkg::EVT_LONG, 1'b0, 1'b1, 1'b0, 1'b1,
                           cscmd_pkg::MOV_STOPPED, 1'b1));
        wait_idle();
    endtask

    // register settings from both extremes and at random, each with a burst of gestures
    task automatic test_random_phases();
        int                  first;
        cscmd_pkg::t_in_item ev;
        logic [8:0]          raw;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                load_config(1'b0, 1'b0, cscmd_pkg::MODE_IMMEDIATE, cscmd_pkg::MODE_IMMEDIATE,
                            4'd0, 4'd0);
            else if (p == 1)
                load_config(1'b1, 1'b1, cscmd_pkg::MODE_HYBRID, cscmd_pkg::MODE_HYBRID,
                            4'd15, 4'd15);
            else
                load_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS) begin
                // reroll idling now and then so some stretches run flat out
                if ($urandom_range(0, 15) == 0) begin
                    send_idle = $urandom_range(0, 3) != 0;
                    take_idle = $urandom_range(0, 3) != 0;
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_gesture();
                end else begin
                    raw = 9'($urandom_range(0, 511));
                    ev  = raw;
                    send_event(ev);
                end
            end
            // hold off until every owed result is back before touching registers
            wait_idle();
        end
        send_idle = 1'b1;
        take_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls and checking
    // ------------------------------------------------------------------

    initial begin : take_results
        int stall;
        cmd_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = take_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                cmd_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cmd_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!cmd_ch.valid);
        end
    end

    always @(posedge i_clk) begin : check_results
        cscmd_pkg::t_out_item want;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            if (expected_cmds.size() == 0) begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display({"%0t: result with nothing owed: ",
                              "action %0d changed %0d local %0d bound %0d"},
                             $realtime, cmd_ch.action, cmd_ch.action_changed,
                             cmd_ch.lcl_cmd, cmd_ch.bound_cmd);
            end else begin
                want = expected_cmds.pop_front();
                if (cmd_ch.action !== want.action ||
                    cmd_ch.action_changed !== want.action_changed ||
                    cmd_ch.lcl_cmd !== want.lcl_cmd ||
                    cmd_ch.bound_cmd !== want.bound_cmd) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display({"%0t: mismatch: action %0d/%0d changed %0d/%0d ",
                                  "local %0d/%0d bound %0d/%0d (expected/actual)"},
                                 $realtime, want.action, cmd_ch.action,
                                 want.action_changed, cmd_ch.action_changed,
                                 want.lcl_cmd, cmd_ch.lcl_cmd,
                                 want.bound_cmd, cmd_ch.bound_cmd);
                end else begin
                    results_ok++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        // every input known from time zero, reset held before the tests start
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= cscmd_pkg::REG_SW_KIND;
        cfg_wdata            <= '0;
        ev_ch.valid          <= 1'b0;
        ev_ch.command        <= cscmd_pkg::EVT_PRESS;
        ev_ch.open_pressed   <= 1'b0;
        ev_ch.close_pressed  <= 1'b0;
        ev_ch.open_long      <= 1'b0;
        ev_ch.close_long     <= 1'b0;
        ev_ch.local_moving   <= cscmd_pkg::MOV_STOPPED;
        ev_ch.network_joined <= 1'b0;
        cfg_mirror.sw_kind      = cscmd_pkg::RST_SW_KIND;
        cfg_mirror.reversal     = cscmd_pkg::RST_REVERSAL;
        cfg_mirror.lcl_mode     = cscmd_pkg::RST_LCL_MODE;
        cfg_mirror.bound_mode   = cscmd_pkg::RST_BOUND_MODE;
        cfg_mirror.cover_number = cscmd_pkg::RST_COVER_NUMBER;
        cfg_mirror.cover_count  = cscmd_pkg::RST_COVER_COUNT;
        action_now    = cscmd_pkg::ACT_RELEASED;
        remote_motion = cscmd_pkg::MOV_STOPPED;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_buttons();
        test_toggle_reversal();
        test_cover_selection();
        test_random_phases();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (expected_cmds.size() != 0) begin
            error_cnt++;
            $display("%0d results never arrived", expected_cmds.size());
        end

        $display("%0d event items, %0d register writes, %0d random settings",
                 items_sent, cfg_writes, settings);
        $display("%0d results matched", results_ok);
        $display("covered both switch types, reversal, all cover modes, missing local cover");
        if (error_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
